### hdl/mcic_pkg.sv
// ============================================================================
// mcic_pkg
// Shared types and constants of the minimum-cost interval cover block.
// ============================================================================
package mcic_pkg;

    localparam int COST_W = 22;
    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};
    localparam int RADICAND_W = 36;

    localparam logic [1:0] CFG_STRIP_LENGTH = 2'd0;
    localparam logic [1:0] CFG_STRIP_WIDTH  = 2'd1;

    typedef struct packed {
        logic [15:0] sprinkler_position;
        logic [15:0] sprinkler_radius;
        logic [15:0] sprinkler_cost;
        logic        last_item;
    } t_item;

    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              covered;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_SQ_GO,
        S_SQ_WAIT,
        S_ENDS,
        S_INS,
        S_INS_CMP,
        S_CLOSE,
        S_ROW_RD,
        S_ROW_LAT,
        S_COL_RD,
        S_COL_WR,
        S_FIN_RD,
        S_FIN
    } t_state;

endpackage

### hdl/mcic_sqrt.sv
// ============================================================================
// mcic_sqrt
// Digit-by-digit square root, one result bit per cycle. The root carries
// FRAC_BITS-1 fraction bits beyond the integer root of the radicand.
// ============================================================================
module mcic_sqrt
    import mcic_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [RADICAND_W-1:0]   i_radicand,
    output logic                    o_done,
    output logic [FRAC_BITS+16:0]   o_root
);
    localparam int RW   = FRAC_BITS + 17;
    localparam int ITER = FRAC_BITS + 17;
    localparam int NW   = $clog2(ITER + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [NW-1:0]         r_cnt;
    logic [RADICAND_W-1:0] r_d;
    logic [RW+1:0]         r_rem;
    logic [RW-1:0]         r_root;

    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic [RW+1:0] n_rem;
    logic [RW-1:0] n_root;

    always_comb begin
        rem_sh = {r_rem, r_d[RADICAND_W-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        diff   = rem_sh - trial;
        if (rem_sh >= trial) begin
            n_rem  = diff[RW+1:0];
            n_root = {r_root[RW-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh[RW+1:0];
            n_root = {r_root[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_d    <= {r_d[RADICAND_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### hdl/min_cost_interval_cover.sv
// ============================================================================
// min_cost_interval_cover
// Sorts sprinklers by position as they load and finds the cheapest set whose
// intervals cover the strip, using a one-row cost table held in memory.
// ============================================================================
// A kept sprinkler computes its square root and then steps past each larger
// entry of the sorted store; a dropped one that does not close the set leaves
// the block idle. The closing beat runs the cost table sweep, whose pace is
// set by the single read port of the cost row memory.
// One beat is in flight at a time; the result strobe lasts one cycle and the receiver cannot stall.
// Reset clears the count, the strip length and width, the result strobe and the control state; no memory sweep.
module min_cost_interval_cover
    import mcic_pkg::*;
#(
    parameter int MAX_SPRINKLERS = 64,
    parameter int FRAC_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_result_valid,
    output t_result     o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int RW = FRAC_BITS + 17;          // reach
    localparam int LW = FRAC_BITS + 18;          // signed left end
    localparam int PW = FRAC_BITS + 17;          // right end
    localparam int EW = 16 + LW + PW + 16;       // store entry
    localparam int SW = (MAX_SPRINKLERS > 1) ? $clog2(MAX_SPRINKLERS) : 1;
    localparam int TW = $clog2(MAX_SPRINKLERS + 1);
    localparam int CW = $clog2(MAX_SPRINKLERS + 1);

    t_state r_state, n_state;

    logic [15:0] r_len, r_width;
    logic [15:0] r_pos, r_rad, r_cost, r_w;
    logic        r_last;
    logic [31:0] r_rsq, r_wsq;
    logic [RADICAND_W-1:0] r_d;
    logic [EW-1:0] r_new;
    logic [CW-1:0] r_count, r_n, r_i, r_j;
    logic          r_init;
    logic [PW-1:0] r_right_i;
    logic [COST_W-1:0] r_take;
    logic          r_out_valid;
    t_result       r_out;

    logic [EW-1:0]     store_mem [MAX_SPRINKLERS];
    logic [COST_W-1:0] row_mem   [MAX_SPRINKLERS + 1];
    logic [EW-1:0]     r_st_rd;
    logic [COST_W-1:0] r_tab_rd;

    logic          st_we;
    logic [SW-1:0] st_waddr, st_raddr;
    logic [EW-1:0] st_wdata;
    logic          tab_we;
    logic [TW-1:0] tab_raddr;
    logic [COST_W-1:0] tab_wdata;

    logic          sq_done;
    logic [RW-1:0] sq_root;

    logic          accept, kept;
    logic [CW-1:0] jm1;
    logic [LW-1:0] limit_j;
    logic          le0;
    logic [COST_W:0] take_sum;

    assign accept      = start && !busy;
    assign kept        = {i_item.sprinkler_radius, 1'b0} > {1'b0, r_width};
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign jm1         = r_j - 1'b1;

    mcic_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_SQ_GO),
        .i_radicand (r_d),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    // Entry layout: {position, left end, right end, cost}.
    always_comb begin
        if (r_j == r_n) begin
            limit_j = {2'b00, r_len, {FRAC_BITS{1'b0}}};
        end else begin
            limit_j = r_st_rd[16+PW +: LW];
        end
        le0      = limit_j[LW-1] || (limit_j == '0);
        take_sum = {1'b0, r_tab_rd} + {{(COST_W-15){1'b0}}, r_st_rd[15:0]};
    end

    always_comb begin
        n_state   = r_state;
        st_we     = 1'b0;
        st_waddr  = r_j[SW-1:0];
        st_wdata  = r_new;
        st_raddr  = r_j[SW-1:0];
        tab_we    = 1'b0;
        tab_raddr = r_j[TW-1:0];
        tab_wdata = r_tab_rd;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (kept && r_count < CW'(MAX_SPRINKLERS)) begin
                        n_state = S_MUL;
                    end else if (i_item.last_item) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_MUL:     n_state = S_SUB;
            S_SUB:     n_state = S_SQ_GO;
            S_SQ_GO:   n_state = S_SQ_WAIT;
            S_SQ_WAIT: if (sq_done) n_state = S_ENDS;
            S_ENDS:    n_state = S_INS;
            S_INS: begin
                st_raddr = jm1[SW-1:0];
                if (r_j == '0) begin
                    st_we   = 1'b1;
                    n_state = r_last ? S_CLOSE : S_IDLE;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                st_we = 1'b1;
                if (r_st_rd[EW-1 -: 16] > r_new[EW-1 -: 16]) begin
                    st_wdata = r_st_rd;
                    n_state  = S_INS;
                end else begin
                    n_state = r_last ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:  n_state = S_COL_RD;
            S_ROW_RD: begin
                st_raddr  = r_i[SW-1:0];
                tab_raddr = r_i[TW-1:0];
                n_state   = S_ROW_LAT;
            end
            S_ROW_LAT: n_state = S_COL_RD;
            S_COL_RD:  n_state = S_COL_WR;
            S_COL_WR: begin
                tab_we = 1'b1;
                if (le0) begin
                    tab_wdata = '0;
                end else if (r_init) begin
                    tab_wdata = COST_INF;
                end else if (($signed({1'b0, r_right_i}) >= $signed(limit_j))
                             && (r_take <= r_tab_rd)) begin
                    tab_wdata = r_take;
                end
                if (r_j == r_n) begin
                    if (r_init) begin
                        n_state = (r_n == '0) ? S_FIN_RD : S_ROW_RD;
                    end else if (r_i == r_n - 1'b1) begin
                        n_state = S_FIN_RD;
                    end else begin
                        n_state = S_ROW_RD;
                    end
                end else begin
                    n_state = S_COL_RD;
                end
            end
            S_FIN_RD: begin
                tab_raddr = r_n[TW-1:0];
                n_state   = S_FIN;
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_width     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_FIN);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STRIP_LENGTH: r_len   <= i_cfg_data;
                    CFG_STRIP_WIDTH:  r_width <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_INS && r_j == '0) ||
                (r_state == S_INS_CMP && r_st_rd[EW-1 -: 16] <= r_new[EW-1 -: 16])) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == S_FIN) begin
                r_count <= '0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos  <= i_item.sprinkler_position;
            r_rad  <= i_item.sprinkler_radius;
            r_cost <= i_item.sprinkler_cost;
            r_last <= i_item.last_item;
            r_w    <= r_width;
        end
        case (r_state)
            S_MUL: begin
                r_rsq <= 32'(r_rad) * 32'(r_rad);
                r_wsq <= 32'(r_w) * 32'(r_w);
            end
            S_SUB: r_d <= {2'b00, r_rsq, 2'b00} - {4'b0000, r_wsq};
            S_ENDS: begin
                r_new <= {r_pos,
                          LW'($signed({2'b00, r_pos, {FRAC_BITS{1'b0}}})
                              - $signed({1'b0, sq_root})),
                          PW'({1'b0, r_pos, {FRAC_BITS{1'b0}}} + {1'b0, sq_root}),
                          r_cost};
                r_j   <= r_count;
            end
            S_INS_CMP: if (r_st_rd[EW-1 -: 16] > r_new[EW-1 -: 16]) r_j <= jm1;
            S_CLOSE: begin
                r_n    <= r_count;
                r_i    <= '0;
                r_j    <= '0;
                r_init <= 1'b1;
            end
            S_ROW_LAT: begin
                r_right_i <= r_st_rd[16 +: PW];
                r_take    <= take_sum[COST_W] || (take_sum[COST_W-1:0] == COST_INF)
                             ? COST_INF : take_sum[COST_W-1:0];
            end
            S_COL_WR: begin
                if (r_j == r_n) begin
                    r_j <= '0;
                    if (r_init) begin
                        r_init <= 1'b0;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            S_FIN: begin
                r_out.covered  <= (r_tab_rd != COST_INF);
                r_out.min_cost <= (r_tab_rd != COST_INF) ? r_tab_rd : '0;
            end
            default: ;
        endcase
    end

    // Sprinkler store and cost row, one read and one write port each.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            store_mem[st_waddr] <= st_wdata;
        end
        r_st_rd <= store_mem[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            row_mem[r_j[TW-1:0]] <= tab_wdata;
        end
        r_tab_rd <= row_mem[tab_raddr];
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

### hdl/mcic_checker.sv
// ============================================================================
// mcic_checker
// Port-level checks of the interval cover block, bound to the top level.
// ============================================================================
module mcic_checker
    import mcic_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_item   i_item,
    input logic    o_result_valid,
    input t_result o_result
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid && !busy)
        else $error("block not quiet after reset");

    // A closing beat always starts the table sweep.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.last_item |=> busy)
        else $error("busy did not rise after an accepted closing beat");

    a_no_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> !o_result_valid)
        else $error("result strobe right after an accepted beat");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_result.covered |-> o_result.min_cost == '0)
        else $error("uncovered result with nonzero cost");

endmodule

bind min_cost_interval_cover mcic_checker u_mcic_checker (.*);

### dv/min_cost_interval_cover_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// min_cost_interval_cover_tb
// Drives sprinkler sets through the cover block and checks every result
// beat against a cycle-free predictor of the sort and cost-table sweep.
// ============================================================================
module min_cost_interval_cover_tb;
    import mcic_pkg::*;

    localparam int MAX_SPR = 64;
    localparam int FRAC    = 16;
    localparam int ITEMS   = 1850;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        o_result_valid;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    min_cost_interval_cover i_dut (.*);

    // Predictor state.
    logic [15:0]     strip_len, strip_wid;
    logic [15:0]     spr_pos  [MAX_SPR];
    longint unsigned spr_reach[MAX_SPR];
    logic [15:0]     spr_cost [MAX_SPR];
    int              spr_count;

    t_result cover_expect_q[$];
    int      mismatches;
    int      items_sent;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic longint unsigned fixed_root(longint unsigned d);
        longint unsigned rem, root, trial, pair;
        rem  = 0;
        root = 0;
        for (int k = 17 + (FRAC - 1); k >= 0; k--) begin
            pair = 0;
            if (k >= FRAC - 1) pair = (d >> (2 * (k - (FRAC - 1)))) & 64'd3;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic [COST_W-1:0] sat_sum(logic [COST_W-1:0] a, logic [15:0] b);
        logic [31:0] s;
        s = a + b;
        return (s >= COST_INF) ? COST_INF : s[COST_W-1:0];
    endfunction

    // Stable insertion sort, then the row-by-row cover cost sweep.
    function automatic t_result close_set();
        int              n;
        logic [15:0]     tp, tc;
        longint unsigned tr;
        longint          lim[MAX_SPR+1];
        longint          right;
        logic [COST_W-1:0] prev[MAX_SPR+1], cur[MAX_SPR+1];
        logic [COST_W-1:0] skip, take, res;
        t_result         r;
        n = spr_count;
        for (int i = 1; i < n; i++) begin
            for (int j = i; j > 0 && spr_pos[j] < spr_pos[j-1]; j--) begin
                tp = spr_pos[j];  spr_pos[j]  = spr_pos[j-1];  spr_pos[j-1]  = tp;
                tr = spr_reach[j]; spr_reach[j] = spr_reach[j-1]; spr_reach[j-1] = tr;
                tc = spr_cost[j]; spr_cost[j] = spr_cost[j-1]; spr_cost[j-1] = tc;
            end
        end
        for (int i = 0; i < n; i++)
            lim[i] = (longint'(spr_pos[i]) <<< FRAC) - longint'(spr_reach[i]);
        lim[n] = longint'(strip_len) <<< FRAC;
        if (n == 0) begin
            res = (lim[0] <= 0) ? '0 : COST_INF;
        end else begin
            for (int j = 0; j <= n; j++) prev[j] = (lim[j] <= 0) ? '0 : COST_INF;
            for (int i = 0; i < n; i++) begin
                right = (longint'(spr_pos[i]) <<< FRAC) + longint'(spr_reach[i]);
                for (int j = 0; j <= n; j++) begin
                    if (lim[j] <= 0) begin
                        cur[j] = '0;
                    end else begin
                        skip   = prev[j];
                        cur[j] = skip;
                        if (right >= lim[j]) begin
                            take = sat_sum(prev[i], spr_cost[i]);
                            if (take <= skip) cur[j] = take;
                        end
                    end
                end
                prev = cur;
            end
            res = prev[n];
        end
        spr_count = 0;
        if (res >= COST_INF) r = '{min_cost: '0, covered: 1'b0};
        else r = '{min_cost: res, covered: 1'b1};
        return r;
    endfunction

    function automatic void load_sprinkler(t_item it);
        longint unsigned d, rr, ww;
        rr = it.sprinkler_radius;
        ww = strip_wid;
        if (2 * rr > ww && spr_count < MAX_SPR) begin
            d = 4 * rr * rr - ww * ww;
            spr_pos[spr_count]   = it.sprinkler_position;
            spr_reach[spr_count] = fixed_root(d);
            spr_cost[spr_count]  = it.sprinkler_cost;
            spr_count++;
        end
        if (it.last_item) cover_expect_q.insert(cover_expect_q.size(), close_set());
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (cover_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: cost %0d covered %0b",
                             o_result.min_cost, o_result.covered);
            end else begin
                t_result e;
                e = cover_expect_q.pop_front();
                if (o_result.min_cost !== e.min_cost || o_result.covered !== e.covered) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected cost %0d covered %0b, got %0d %0b",
                                 e.min_cost, e.covered, o_result.min_cost, o_result.covered);
                end
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with start still high.
    task automatic send_item(t_item it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        load_sprinkler(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fields(int p, int r, int c, bit last);
        t_item it;
        it.sprinkler_position = p[15:0];
        it.sprinkler_radius   = r[15:0];
        it.sprinkler_cost     = c[15:0];
        it.last_item          = last;
        send_item(it);
    endtask

    // Waits until every expected result beat has arrived and the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (cover_expect_q.size() != 0) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Leaves valid low for a full falling edge before returning.
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_STRIP_LENGTH) strip_len = val;
        else if (idx == CFG_STRIP_WIDTH) strip_wid = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_strip(int len, int wid);
        drain();
        write_reg(CFG_STRIP_LENGTH, len[15:0]);
        write_reg(CFG_STRIP_WIDTH, wid[15:0]);
    endtask

    task automatic test_extremes();
        set_strip(0, 0);
        send_fields(0, 0, 0, 1);              // empty set, zero length
        set_strip(100, 10);
        send_fields(5, 5, 7, 1);              // radius exactly half the width: dropped
        send_fields(50, 65535, 65535, 1);     // one sprinkler reaching everything
        send_fields(65535, 65535, 1, 0);
        send_fields(0, 6, 3, 0);
        send_fields(100, 0, 3, 1);            // dropped sprinkler still closes
        set_strip(65535, 65535);
        send_fields(32767, 65535, 65535, 0);
        send_fields(65535, 32768, 2, 1);
        set_strip(10, 0);
        send_fields(3, 2, 4, 0);
        send_fields(1, 2, 5, 0);
        send_fields(8, 3, 6, 0);
        send_fields(3, 4, 9, 1);
    endtask

    task automatic test_store_full();
        set_strip(700, 2);
        for (int i = 0; i < 70; i++)
            send_fields(i * 10, 6 + (i % 3), $urandom_range(0, 65535), i == 69);
    endtask

    // A width change while a set is open applies to later sprinklers only.
    task automatic test_width_mid_set();
        set_strip(40, 4);
        send_fields(10, 12, 5, 0);
        drain();
        write_reg(CFG_STRIP_WIDTH, 16'd30);
        send_fields(30, 16, 8, 0);
        send_fields(20, 10, 1, 1);
    endtask

    task automatic test_random_sets();
        int n, len;
        while (items_sent < ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 300);
                set_strip(len, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 40));
            end
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    send_fields($urandom_range(0, 65535), $urandom_range(0, 65535),
                                $urandom_range(0, 65535), $urandom_range(0, 1));
            end else begin
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 68)
                                                 : $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                    send_fields($urandom_range(0, strip_len + 20),
                                $urandom_range(0, strip_wid / 2 + 80),
                                $urandom_range(0, 65535), i == n - 1);
            end
            if ($urandom_range(0, 19) == 0) drain();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_STRIP_LENGTH;
        i_cfg_data  = '0;
        strip_len   = '0;
        strip_wid   = '0;
        spr_count   = 0;
        mismatches  = 0;
        items_sent  = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_store_full();
        test_width_mid_set();
        test_random_sets();
        drain();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && cover_expect_q.size() == 0) begin
            $display("min_cost_interval_cover_tb passed");
        end else begin
            $display("min_cost_interval_cover_tb failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("min_cost_interval_cover_tb failed");
        $finish;
    end

endmodule
